FILE: rtl/core/hwa_pkg.sv
`timescale 1ns / 1ps

package hwa_pkg;

    // Datapath widths
    localparam int AW = 48;     // dividend / numerator width, signed
    localparam int BW = 32;     // projective term width, signed

    // Config register indexes
    localparam logic [1:0] CFG_DST_HEIGHT = 2'd0;
    localparam logic [1:0] CFG_SRC_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_SRC_HEIGHT = 2'd2;
    localparam logic [10:0] CFG_RESET_DIM = 11'd1024;

    // Homography coefficients, Q.24, rounded to nearest
    localparam logic signed [AW-1:0] H00 = 48'sd3269879;
    localparam logic signed [AW-1:0] H01 = 48'sd44075424;
    localparam logic signed [AW-1:0] H10 = -48'sd21367462;
    localparam logic signed [AW-1:0] H11 = 48'sd19919589;
    localparam logic signed [AW-1:0] H20 = 48'sd5033;
    localparam logic signed [AW-1:0] H21 = -48'sd50332;
    // Offsets are doubled to match the doubled coordinates
    localparam logic signed [AW-1:0] C02 = -48'sd13747733974;
    localparam logic signed [AW-1:0] C12 = 48'sd17576103406;
    localparam logic signed [AW-1:0] C22 = 48'sd33554432;

    // Boundary lines, constants scaled by 10000, doubled coordinates
    localparam int L1_LIM = 3547199;
    localparam int L2_OFS = 1471;
    localparam int L3_OFS = 6162499;
    localparam int L4_LIM = 842697;

    typedef struct packed {
        logic                 ok;
        logic signed [AW-1:0] a_col;
        logic signed [AW-1:0] a_row;
        logic signed [BW-1:0] b;
    } t_div_in;

endpackage

FILE: rtl/core/hwa_front.sv
`timescale 1ns / 1ps

// Coordinate setup, region test, projection and dividend forming: six stages.
module hwa_front #(
    parameter int MAX_DIM = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [9:0]          i_row,
    input  logic [9:0]          i_col,
    input  logic [10:0]         i_dst_height,
    input  logic [10:0]         i_src_height,
    output logic                o_valid,
    input  logic                i_ready,
    output hwa_pkg::t_div_in    o_div
);

    logic [6:1] r_v;
    logic [7:1] w_rdy;

    // stage 1
    logic [9:0] r_row, r_col;
    // stage 2
    logic                 r_ok2;
    logic signed [11:0]   r_x2;
    logic signed [12:0]   r_y2;
    logic                 n_ok2;
    logic signed [11:0]   n_x2;
    logic signed [12:0]   n_y2;
    // stage 3
    logic signed [31:0]   n_xs, n_ys;
    logic                 n_in;
    logic                 r_ok3;
    logic signed [hwa_pkg::AW-1:0] r_t00, r_t01, r_t10, r_t11, r_t20, r_t21;
    // stage 4
    logic signed [hwa_pkg::AW-1:0] n_n0, n_n1, n_d;
    logic                 r_ok4;
    logic signed [hwa_pkg::AW-1:0] r_n0, r_n1;
    logic signed [hwa_pkg::BW-1:0] r_d;
    // stage 5
    logic signed [43:0]   n_p;
    logic signed [hwa_pkg::AW-1:0] n_acol;
    logic                 r_ok5;
    logic signed [hwa_pkg::AW-1:0] r_acol, r_n1b;
    logic signed [hwa_pkg::BW-1:0] r_b, r_db;
    logic signed [43:0]   r_p;
    // stage 6
    hwa_pkg::t_div_in     r_out;

    always_comb begin
        w_rdy[7] = i_ready;
        for (int k = 6; k >= 1; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[1];
    assign o_valid = r_v[6];
    assign o_div   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[1]) r_v[1] <= i_valid;
            for (int k = 2; k <= 6; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // frame check and doubled centred coordinates
    always_comb begin
        n_ok2 = ({1'b0, r_row} < i_dst_height) && (32'(r_col) < MAX_DIM);
        n_x2  = $signed({1'b0, r_col, 1'b1});
        n_y2  = $signed({1'b0, i_dst_height, 1'b0}) - $signed({2'b00, r_row, 1'b0})
              - 13'sd1;
    end

    // region test against the four lines
    always_comb begin
        n_xs = 32'(r_x2);
        n_ys = 32'(r_y2);
        n_in = !(8600 * n_ys + 200 * n_xs > hwa_pkg::L1_LIM)
            && !(4 * n_ys > 3 * n_xs - hwa_pkg::L2_OFS)
            && !(7000 * n_ys < 7500 * n_xs - hwa_pkg::L3_OFS)
            && !(2700 * n_ys + 200 * n_xs < hwa_pkg::L4_LIM);
    end

    always_comb begin
        n_n0 = r_t00 + r_t01 + hwa_pkg::C02;
        n_n1 = r_t10 + r_t11 + hwa_pkg::C12;
        n_d  = r_t20 + r_t21 + hwa_pkg::C22;
    end

    always_comb begin
        n_p    = 44'($signed({1'b0, i_src_height})) * 44'(r_d);
        n_acol = (r_n0 <<< 1) - hwa_pkg::AW'(r_d);
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_row <= i_row;
            r_col <= i_col;
        end
        if (w_rdy[2]) begin
            r_ok2 <= n_ok2;
            r_x2  <= n_x2;
            r_y2  <= n_y2;
        end
        if (w_rdy[3]) begin
            r_ok3 <= r_ok2 && n_in;
            r_t00 <= hwa_pkg::H00 * hwa_pkg::AW'(r_x2);
            r_t01 <= hwa_pkg::H01 * hwa_pkg::AW'(r_y2);
            r_t10 <= hwa_pkg::H10 * hwa_pkg::AW'(r_x2);
            r_t11 <= hwa_pkg::H11 * hwa_pkg::AW'(r_y2);
            r_t20 <= hwa_pkg::H20 * hwa_pkg::AW'(r_x2);
            r_t21 <= hwa_pkg::H21 * hwa_pkg::AW'(r_y2);
        end
        if (w_rdy[4]) begin
            r_ok4 <= r_ok3 && (n_d != '0);
            r_n0  <= n_n0;
            r_n1  <= n_n1;
            r_d   <= hwa_pkg::BW'(n_d);
        end
        if (w_rdy[5]) begin
            r_ok5  <= r_ok4;
            r_acol <= n_acol;
            r_b    <= r_d <<< 1;
            r_db   <= r_d;
            r_n1b  <= r_n1;
            r_p    <= n_p;
        end
        if (w_rdy[6]) begin
            r_out.ok    <= r_ok5;
            r_out.a_col <= r_acol;
            r_out.a_row <= (hwa_pkg::AW'(r_p) <<< 1) - (r_n1b <<< 1)
                         - hwa_pkg::AW'(r_db);
            r_out.b     <= r_b;
        end
    end

endmodule

FILE: rtl/core/hwa_div.sv
`timescale 1ns / 1ps

// Two-lane pipelined restoring divider sharing one divisor.
// Stage 0 forces a positive divisor, stage 1 range-checks, then one bit a stage.
module hwa_div #(
    parameter int QW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  hwa_pkg::t_div_in  i_div,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_ok,
    output logic [QW-1:0]     o_q_col,
    output logic [QW-1:0]     o_q_row
);

    localparam int NS = QW + 2;

    typedef struct packed {
        logic                          ok;
        logic signed [hwa_pkg::AW-1:0] rc;
        logic signed [hwa_pkg::AW-1:0] rr;
        logic signed [hwa_pkg::AW-1:0] bs;
        logic [QW-1:0]                 qc;
        logic [QW-1:0]                 qr;
    } t_dst;

    t_dst r_st [NS];
    t_dst n_st [NS];
    logic [NS-1:0] r_v;
    logic [NS:0]   w_rdy;

    function automatic t_dst bit_step(input t_dst s, input int sh);
        t_dst o;
        logic signed [hwa_pkg::AW-1:0] dsh;
        logic gc, gr;
        o   = s;
        dsh = s.bs <<< sh;
        gc  = s.rc >= dsh;
        gr  = s.rr >= dsh;
        if (gc) o.rc = s.rc - dsh;
        if (gr) o.rr = s.rr - dsh;
        o.qc = QW'({s.qc, gc});
        o.qr = QW'({s.qr, gr});
        return o;
    endfunction

    always_comb begin
        logic neg;
        logic signed [hwa_pkg::AW-1:0] bx, lim;
        neg = i_div.b[hwa_pkg::BW-1];
        bx  = hwa_pkg::AW'(i_div.b);
        n_st[0].ok = i_div.ok;
        n_st[0].rc = neg ? -i_div.a_col : i_div.a_col;
        n_st[0].rr = neg ? -i_div.a_row : i_div.a_row;
        n_st[0].bs = neg ? -bx : bx;
        n_st[0].qc = '0;
        n_st[0].qr = '0;

        // quotient must fit in QW bits, dividends non-negative
        lim = r_st[0].bs <<< QW;
        n_st[1]    = r_st[0];
        n_st[1].ok = r_st[0].ok && !r_st[0].rc[hwa_pkg::AW-1]
                  && !r_st[0].rr[hwa_pkg::AW-1]
                  && (r_st[0].rc < lim) && (r_st[0].rr < lim);

        for (int k = 0; k < QW; k++) begin
            n_st[k+2] = bit_step(r_st[k+1], QW - 1 - k);
        end
    end

    always_comb begin
        w_rdy[NS] = i_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NS; k++) begin
                if (w_rdy[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (w_rdy[k]) r_st[k] <= n_st[k];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NS-1];
    assign o_ok    = r_st[NS-1].ok;
    assign o_q_col = r_st[NS-1].qc;
    assign o_q_row = r_st[NS-1].qr;

endmodule

FILE: rtl/core/homography_warp_address_core.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Word
// s_axis    in   s_axis_tvalid/tready/tdata       tdata: dst_row[9:0], dst_col[19:10]
// m_axis    out  m_axis_tvalid/tready/tdata/tuser tdata: src_row[9:0], src_col[19:10];
//                                                 tuser: hit
// cfg       in   i_cfg_we/i_cfg_idx/i_cfg_data    0 dst_height, 1 src_width, 2 src_height
//
// One word per clock sustained while m_axis is ready; the path runs through
// the front's 6 stages, the divider's clog2(MAX_DIM)+2 stages and 1 output register.
// Latency is set by the one-bit-per-stage divider.
// Every stage has its own valid bit; a stall at m_axis fills empty stages first,
// so bubbles collapse and nothing is lost or repeated.
// Synchronous active-low reset clears valids; config registers reset to 1024.
module homography_warp_address_core #(
    parameter int MAX_DIM = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [9:0] dst_row, [19:10] dst_col, [23:20] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [9:0] src_row, [19:10] src_col, [23:20] zero
    output logic        m_axis_tuser,   // [0] hit
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data
);

    localparam int QW = $clog2(MAX_DIM);
    localparam logic [12:0] MAXD = 13'(MAX_DIM);

    logic [10:0] r_dst_height, r_src_width, r_src_height;

    logic             w_f_valid, w_f_ready;
    hwa_pkg::t_div_in w_f_div;
    logic             w_d_valid, w_d_ready, w_d_ok;
    logic [QW-1:0]    w_q_col, w_q_row;

    logic [12:0] w_wb, w_hb;
    logic        n_hit;

    logic        r_ov;
    logic        r_hit;
    logic [9:0]  r_src_row, r_src_col;

    // config writes; the host must write only while no word is in flight (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dst_height <= hwa_pkg::CFG_RESET_DIM;
            r_src_width  <= hwa_pkg::CFG_RESET_DIM;
            r_src_height <= hwa_pkg::CFG_RESET_DIM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                hwa_pkg::CFG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                hwa_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                hwa_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    hwa_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_row        (s_axis_tdata[9:0]),
        .i_col        (s_axis_tdata[19:10]),
        .i_dst_height (r_dst_height),
        .i_src_height (r_src_height),
        .o_valid      (w_f_valid),
        .i_ready      (w_f_ready),
        .o_div        (w_f_div)
    );

    hwa_div #(
        .QW (QW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_div   (w_f_div),
        .o_valid (w_d_valid),
        .i_ready (w_d_ready),
        .o_ok    (w_d_ok),
        .o_q_col (w_q_col),
        .o_q_row (w_q_row)
    );

    // source bounds clamp to MAX_DIM
    always_comb begin
        w_wb  = ({2'b00, r_src_width}  > MAXD) ? MAXD : {2'b00, r_src_width};
        w_hb  = ({2'b00, r_src_height} > MAXD) ? MAXD : {2'b00, r_src_height};
        n_hit = w_d_ok && (13'(w_q_col) < w_wb) && (13'(w_q_row) < w_hb);
    end

    // output register: refills whenever empty or being drained
    assign w_d_ready = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_d_ready) begin
            r_ov <= w_d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_d_ready) begin
            r_hit     <= n_hit;
            r_src_row <= n_hit ? 10'(w_q_row) : 10'd0;
            r_src_col <= n_hit ? 10'(w_q_col) : 10'd0;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {4'b0000, r_src_col, r_src_row};

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 24'd0)
        else $error("miss word carries nonzero address");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> 13'(r_src_col) < w_wb)
        else $error("hit column outside source width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> 13'(r_src_row) < w_hb)
        else $error("hit row outside source height");

    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid && !w_d_valid)
        else $error("pipeline not empty after reset");
`endif

endmodule
